/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the record sorter. Each helper expects clk and
// rst_n to be visible in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define RSKS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define RSKS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define RSKS_ASSERT_IMP(label, ante, cons)
`define RSKS_ASSERT_NXT(label, ante, cons)

`endif

`endif

/* src/rsks_pkg.sv */
// ----------------------------------------------------------------------------
// rsks_pkg
// Types and constants shared by the record sorter and its sorting cells.
// ----------------------------------------------------------------------------
package rsks_pkg;

    localparam int IN_NAME_W = 64;
    localparam int ID_W      = 32;
    localparam int YEAR_W    = 12;
    localparam int KEY_W     = 2;
    localparam int CFG_W     = 2;

    // Configuration register indexes.
    localparam logic REG_SORT_KEY   = 1'b0;
    localparam logic REG_DESCENDING = 1'b1;

    // Sort key selector codes.
    localparam logic [KEY_W-1:0] KEY_NAME = 2'd0;
    localparam logic [KEY_W-1:0] KEY_ID   = 2'd1;
    localparam logic [KEY_W-1:0] KEY_YEAR = 2'd2;

    // Control broadcast from the sequencer to every cell in the chain.
    typedef struct packed {
        logic             load;
        logic             sort;
        logic             shift;
        logic             phase;
        logic [KEY_W-1:0] key;
        logic             desc;
    } ctrl_t;

endpackage

/* src/rsks_cell.sv */
// ----------------------------------------------------------------------------
// rsks_cell
// One slot of the sorting chain. Holds a record with its load position,
// compare-exchanges with its upper neighbor and shifts down on emission.
// ----------------------------------------------------------------------------
module rsks_cell
    import rsks_pkg::*;
#(
    parameter int POS    = 0,
    parameter int NAME_W = 128,
    parameter int IDX_W  = 6,
    parameter int CNT_W  = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_t             ctrl,
    input  logic [CNT_W-1:0]  count,
    input  logic [NAME_W-1:0] in_name,
    input  logic [ID_W-1:0]   in_id,
    input  logic [YEAR_W-1:0] in_year,
    input  logic              up_valid,
    input  logic [NAME_W-1:0] up_name,
    input  logic [ID_W-1:0]   up_id,
    input  logic [YEAR_W-1:0] up_year,
    input  logic [IDX_W-1:0]  up_idx,
    input  logic [NAME_W-1:0] dn_name,
    input  logic [ID_W-1:0]   dn_id,
    input  logic [YEAR_W-1:0] dn_year,
    input  logic [IDX_W-1:0]  dn_idx,
    input  logic              dn_swap,
    output logic              valid,
    output logic [NAME_W-1:0] name,
    output logic [ID_W-1:0]   id,
    output logic [YEAR_W-1:0] year,
    output logic [IDX_W-1:0]  idx,
    output logic              swap
);

    localparam logic POS_ODD = ((POS % 2) == 1);

    logic              valid_reg, valid_next;
    logic [NAME_W-1:0] name_reg, name_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [YEAR_W-1:0] year_reg, year_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    logic lower;
    logic key_gt;
    logic key_eq;
    logic want;

    // This cell is the lower member of a compare pair in the matching phase.
    assign lower = (ctrl.phase == POS_ODD);

    always_comb
    begin
        case (ctrl.key)
            KEY_NAME:
            begin
                key_gt = name_reg > up_name;
                key_eq = name_reg == up_name;
            end
            KEY_ID:
            begin
                key_gt = id_reg > up_id;
                key_eq = id_reg == up_id;
            end
            KEY_YEAR:
            begin
                key_gt = year_reg > up_year;
                key_eq = year_reg == up_year;
            end
            default:
            begin
                key_gt = 1'b0;
                key_eq = 1'b1;
            end
        endcase
    end

    // Ties are broken on load position, which keeps the sort stable and makes
    // the descending order the exact reverse of the ascending one.
    always_comb
    begin
        if (ctrl.desc)
            want = (!key_gt && !key_eq) || (key_eq && (idx_reg < up_idx));
        else
            want = key_gt || (key_eq && (idx_reg > up_idx));
    end

    assign swap = ctrl.sort && lower && valid_reg && up_valid && want;

    always_comb
    begin
        valid_next = valid_reg;
        name_next  = name_reg;
        id_next    = id_reg;
        year_next  = year_reg;
        idx_next   = idx_reg;
        if (ctrl.load && (count == CNT_W'(POS)))
        begin
            valid_next = 1'b1;
            name_next  = in_name;
            id_next    = in_id;
            year_next  = in_year;
            idx_next   = IDX_W'(POS);
        end
        else if (swap || ctrl.shift)
        begin
            valid_next = up_valid;
            name_next  = up_name;
            id_next    = up_id;
            year_next  = up_year;
            idx_next   = up_idx;
        end
        else if (ctrl.sort && !lower && dn_swap)
        begin
            name_next  = dn_name;
            id_next    = dn_id;
            year_next  = dn_year;
            idx_next   = dn_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        name_reg <= name_next;
        id_reg   <= id_next;
        year_reg <= year_next;
        idx_reg  <= idx_next;
    end

    assign valid = valid_reg;
    assign name  = name_reg;
    assign id    = id_reg;
    assign year  = year_reg;
    assign idx   = idx_reg;

endmodule

/* src/record_sorter_key_select.sv */
// ----------------------------------------------------------------------------
// record_sorter_key_select
// Loads a batch of student records and returns them stably sorted on a
// selectable key, ascending or in reverse.
// ----------------------------------------------------------------------------
// Usage: records are loaded one beat per clock while busy is low; a record is
// taken on every cycle with start high. The beat with last_record high closes
// the batch, and busy then rises. For a batch of n stored records the block
// then runs n sorting rounds, with the chain of cells performing one odd-even
// compare-exchange round per cycle, and then presents n result beats back to
// back, each marked by result_valid for exactly one cycle. The receiver
// cannot hold results off, so it must take every beat as it appears. busy
// falls after the beat with out_last high. Records beyond MAX_RECORDS are
// dropped and every result of that batch then carries overflow. The sort key
// and direction are sampled when the final record is taken; key code three
// keeps load order, or reverses it when descending. Names are compared
// bytewise unsigned, first byte most significant, over NAME_BYTES bytes;
// bytes past that are zero on output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module record_sorter_key_select
    import rsks_pkg::*;
#(
    parameter int MAX_RECORDS = 64,
    parameter int NAME_BYTES  = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic [IN_NAME_W-1:0] name_high,
    input  logic [IN_NAME_W-1:0] name_low,
    input  logic [ID_W-1:0]      student_id,
    input  logic [YEAR_W-1:0]    grad_year,
    input  logic                 last_record,
    output logic                 result_valid,
    output logic [IN_NAME_W-1:0] out_name_high,
    output logic [IN_NAME_W-1:0] out_name_low,
    output logic [ID_W-1:0]      out_id,
    output logic [YEAR_W-1:0]    out_year,
    output logic                 out_last,
    output logic                 overflow
);

    localparam int NAME_W   = NAME_BYTES * 8;
    localparam int FULL_W   = IN_NAME_W * 2;
    localparam int NAME_PAD = FULL_W - NAME_W;
    localparam int IDX_W    = $clog2(MAX_RECORDS);
    localparam int CNT_W    = $clog2(MAX_RECORDS + 1);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] round_reg, round_next;
    logic             phase_reg, phase_next;
    logic             dropped_reg, dropped_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             desc_reg, desc_next;
    logic [KEY_W-1:0] sort_key_reg;
    logic             descending_reg;

    logic             accept;
    logic             room;
    ctrl_t            ctrl;
    logic [FULL_W-1:0] in_full;
    logic [NAME_W-1:0] in_name;
    logic [FULL_W-1:0] out_full;

    logic              cell_valid [MAX_RECORDS];
    logic [NAME_W-1:0] cell_name  [MAX_RECORDS];
    logic [ID_W-1:0]   cell_id    [MAX_RECORDS];
    logic [YEAR_W-1:0] cell_year  [MAX_RECORDS];
    logic [IDX_W-1:0]  cell_idx   [MAX_RECORDS];
    logic              cell_swap  [MAX_RECORDS];
    logic [MAX_RECORDS-1:0] valid_vec;

    // ------------------------------------------------------------------
    // Configuration registers. Writes land immediately and are sampled
    // into the working copies when a batch closes.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_key_reg   <= KEY_NAME;
            descending_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SORT_KEY:   sort_key_reg   <= cfg_data[KEY_W-1:0];
                REG_DESCENDING: descending_reg <= cfg_data[0];
                default:        descending_reg <= descending_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: load beats, then n compare-exchange rounds, then n
    // result beats shifted out of the bottom cell.
    // ------------------------------------------------------------------
    assign busy   = (state_reg != ST_LOAD);
    assign accept = start && !busy;
    assign room   = (count_reg < CNT_W'(MAX_RECORDS));

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        round_next   = round_reg;
        phase_next   = phase_reg;
        dropped_next = dropped_reg;
        key_next     = key_reg;
        desc_next    = desc_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (room)
                        count_next = count_reg + CNT_W'(1);
                    else
                        dropped_next = 1'b1;
                    if (last_record)
                    begin
                        state_next = ST_SORT;
                        round_next = '0;
                        phase_next = 1'b0;
                        key_next   = sort_key_reg;
                        desc_next  = descending_reg;
                    end
                end
            end
            ST_SORT:
            begin
                // A batch of n records is in order after n alternating rounds.
                phase_next = !phase_reg;
                round_next = round_reg + CNT_W'(1);
                if (round_reg == count_reg - CNT_W'(1))
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                count_next = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    state_next   = ST_LOAD;
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            round_reg   <= '0;
            phase_reg   <= 1'b0;
            dropped_reg <= 1'b0;
            key_reg     <= KEY_NAME;
            desc_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            round_reg   <= round_next;
            phase_reg   <= phase_next;
            dropped_reg <= dropped_next;
            key_reg     <= key_next;
            desc_reg    <= desc_next;
        end
    end

    assign ctrl.load  = accept && room;
    assign ctrl.sort  = (state_reg == ST_SORT);
    assign ctrl.shift = (state_reg == ST_EMIT);
    assign ctrl.phase = phase_reg;
    assign ctrl.key   = key_reg;
    assign ctrl.desc  = desc_reg;

    // Only the leading NAME_BYTES bytes of the name are kept.
    assign in_full = {name_high, name_low};
    assign in_name = in_full[FULL_W-1 -: NAME_W];

    // ------------------------------------------------------------------
    // Chain of cells. Cell zero is the bottom of the chain and holds the
    // next record to emit; the top cell sees an empty neighbor above it.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < MAX_RECORDS; i++)
    begin : g_cell
        logic              up_valid;
        logic [NAME_W-1:0] up_name;
        logic [ID_W-1:0]   up_id;
        logic [YEAR_W-1:0] up_year;
        logic [IDX_W-1:0]  up_idx;
        logic [NAME_W-1:0] dn_name;
        logic [ID_W-1:0]   dn_id;
        logic [YEAR_W-1:0] dn_year;
        logic [IDX_W-1:0]  dn_idx;
        logic              dn_swap;

        if (i < MAX_RECORDS - 1)
        begin : g_up
            assign up_valid = cell_valid[i+1];
            assign up_name  = cell_name[i+1];
            assign up_id    = cell_id[i+1];
            assign up_year  = cell_year[i+1];
            assign up_idx   = cell_idx[i+1];
        end
        else
        begin : g_top
            assign up_valid = 1'b0;
            assign up_name  = '0;
            assign up_id    = '0;
            assign up_year  = '0;
            assign up_idx   = '0;
        end

        if (i > 0)
        begin : g_dn
            assign dn_name = cell_name[i-1];
            assign dn_id   = cell_id[i-1];
            assign dn_year = cell_year[i-1];
            assign dn_idx  = cell_idx[i-1];
            assign dn_swap = cell_swap[i-1];
        end
        else
        begin : g_bottom
            assign dn_name = '0;
            assign dn_id   = '0;
            assign dn_year = '0;
            assign dn_idx  = '0;
            assign dn_swap = 1'b0;
        end

        rsks_cell #(
            .POS    (i),
            .NAME_W (NAME_W),
            .IDX_W  (IDX_W),
            .CNT_W  (CNT_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .count    (count_reg),
            .in_name  (in_name),
            .in_id    (student_id),
            .in_year  (grad_year),
            .up_valid (up_valid),
            .up_name  (up_name),
            .up_id    (up_id),
            .up_year  (up_year),
            .up_idx   (up_idx),
            .dn_name  (dn_name),
            .dn_id    (dn_id),
            .dn_year  (dn_year),
            .dn_idx   (dn_idx),
            .dn_swap  (dn_swap),
            .valid    (cell_valid[i]),
            .name     (cell_name[i]),
            .id       (cell_id[i]),
            .year     (cell_year[i]),
            .idx      (cell_idx[i]),
            .swap     (cell_swap[i])
        );

        assign valid_vec[i] = cell_valid[i];
    end

    // ------------------------------------------------------------------
    // Result beats come straight from the bottom cell.
    // ------------------------------------------------------------------
    assign out_full      = FULL_W'(cell_name[0]) << NAME_PAD;
    assign result_valid  = (state_reg == ST_EMIT);
    assign out_name_high = out_full[FULL_W-1 -: IN_NAME_W];
    assign out_name_low  = out_full[IN_NAME_W-1:0];
    assign out_id        = cell_id[0];
    assign out_year      = cell_year[0];
    assign out_last      = result_valid && (count_reg == CNT_W'(1));
    assign overflow      = dropped_reg;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    // While loading, the filled cells are exactly the stored records.
    `RSKS_ASSERT_IMP(a_load_fill, state_reg == ST_LOAD, CNT_W'($countones(valid_vec)) == count_reg)
    // Every result beat is taken from an occupied cell.
    `RSKS_ASSERT_IMP(a_emit_valid, result_valid, valid_vec[0])
    // The final beat leaves the chain empty and ready for the next batch.
    `RSKS_ASSERT_NXT(a_last_empty, out_last, valid_vec == '0 && count_reg == '0)
    // The block only frees up right after the final result beat.
    `RSKS_ASSERT_IMP(a_busy_fall, $fell(busy), $past(out_last))

endmodule
